// ===== src/ste_pkg.sv =====
`timescale 1ns / 1ps

package ste_pkg;

	// Operation carried in the slave-side tuser.
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// Outcome carried in the master-side tuser.
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic en;   // apply the command this cycle
		cmd_t cmd;
		logic hit;  // some valid cell equals the key
	} cell_ctrl_t;

	localparam int unsigned CAP_WIDTH   = 5;
	localparam int unsigned FIELD_WIDTH = 32;
	localparam int unsigned POS_WIDTH   = 4;
	localparam int unsigned CNT_WIDTH   = 5;

endpackage

// ===== src/ste_cell.sv =====
`timescale 1ns / 1ps

// One slot of the ordered table. It compares its entry with the broadcast key
// and takes its own, its left or its right neighbor's entry on an update.
module ste_cell #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ste_pkg::cell_ctrl_t           ctrl,
	input  logic signed [VALUE_WIDTH-1:0] key,
	input  logic signed [VALUE_WIDTH-1:0] left_value,
	input  logic                          left_valid,
	input  logic                          left_le,
	input  logic signed [VALUE_WIDTH-1:0] right_value,
	input  logic                          right_valid,
	output logic signed [VALUE_WIDTH-1:0] value_q,
	output logic                          valid_q,
	output logic                          le,
	output logic                          lt,
	output logic                          eq
);

	logic take_key;
	logic take_left;
	logic take_right;

	assign le = valid_q && !(key < value_q);
	assign lt = valid_q && (value_q < key);
	assign eq = valid_q && (value_q == key);

	// Insert: the first slot holding a larger entry (or the first free slot)
	// takes the key, every slot above it takes its left neighbor.
	// Delete: every slot at or above the first match takes its right neighbor.
	always_comb begin
		take_key   = 1'b0;
		take_left  = 1'b0;
		take_right = 1'b0;
		if (ctrl.en) begin
			case (ctrl.cmd)
				ste_pkg::CMD_INSERT: begin
					take_key  = !le && left_le;
					take_left = !le && !left_le;
				end
				ste_pkg::CMD_DELETE: begin
					take_right = ctrl.hit && valid_q && !lt;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.en && ctrl.cmd == ste_pkg::CMD_CLEAR) begin
			valid_q <= 1'b0;
		end else if (take_key) begin
			valid_q <= 1'b1;
		end else if (take_left) begin
			valid_q <= left_valid;
		end else if (take_right) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_key) begin
			value_q <= key;
		end else if (take_left) begin
			value_q <= left_value;
		end else if (take_right) begin
			value_q <= right_value;
		end
	end

endmodule

// ===== src/sorted_table_engine.sv =====
`timescale 1ns / 1ps

// A result reaches the master side through the result stage and then the output
// register. A new command is taken only once the single result stage between
// the cell chain and the output register has passed its result on.
// Reset (arst_n low, asynchronous) empties the table, sets the capacity register to
// 16 and drops every pending result; entry storage itself is not cleared.
module sorted_table_engine #(
	parameter int DEPTH       = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [1:0]  s_tuser,  // [1:0] command
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // [3:0] position, [8:4] entry_count,
	                              // [40:9] smallest, [72:41] largest, rest zero
	output logic [1:0]  m_tuser,  // [1:0] status
	// Capacity register write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	// The count has to reach DEPTH itself.
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > ste_pkg::CAP_WIDTH) ? CW : ste_pkg::CAP_WIDTH;

	// Number of ones in a cell flag vector. With a sorted table this is the
	// slot index where the flag run ends.
	function automatic logic [CW-1:0] ones(input logic [DEPTH-1:0] v);
		logic [CW-1:0] n;
		n = '0;
		for (int k = 0; k < DEPTH; k++) begin
			n = n + CW'(v[k]);
		end
		return n;
	endfunction

	logic [ste_pkg::CAP_WIDTH-1:0] cap_q;
	logic [CW-1:0]                 count_q;

	logic                          accept;
	ste_pkg::cmd_t                 cmd;
	logic signed [VALUE_WIDTH-1:0] key;
	logic                          full;
	logic                          hit;
	ste_pkg::cell_ctrl_t           ctrl;

	logic signed [VALUE_WIDTH-1:0] value_w [DEPTH];
	logic [DEPTH-1:0]              valid_w;
	logic [DEPTH-1:0]              le_w;
	logic [DEPTH-1:0]              lt_w;
	logic [DEPTH-1:0]              eq_w;

	logic                          s1_valid_q;
	ste_pkg::status_t              status_s1;
	logic [ste_pkg::POS_WIDTH-1:0] pos_s1;
	ste_pkg::status_t              status_w;
	logic [CW-1:0]                 pos_w;

	logic                          move;
	logic signed [VALUE_WIDTH-1:0] largest_w;
	logic signed [31:0]            smallest_32;
	logic signed [31:0]            largest_32;
	logic                          m_tvalid_q;
	logic [79:0]                   m_tdata_q;
	logic [1:0]                    m_tuser_q;

	// The capacity register takes a write in every cycle; the user must see that it is only
	// written while the table is idle, which the block itself does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= ste_pkg::CAP_WIDTH'(16);
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// A command is taken only when the result stage is empty, so the chain
	// never changes under a result that has not yet left for the output.
	assign s_tready = !s1_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign cmd      = ste_pkg::cmd_t'(s_tuser);
	// Reduce the operand to the stored width, sign-extending as needed.
	assign key      = VALUE_WIDTH'($signed(s_tdata));

	// The effective limit is the register clamped to the built depth.
	assign full = (count_q == CW'(DEPTH)) || (LW'(count_q) >= LW'(cap_q));
	assign hit  = |eq_w;

	always_comb begin
		ctrl.en  = accept && !(cmd == ste_pkg::CMD_INSERT && full);
		ctrl.cmd = cmd;
		ctrl.hit = hit;
	end

	// The chain of cells. Slot 0 sees a virtual left neighbor that is less
	// than everything; the top slot sees an empty right neighbor.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [VALUE_WIDTH-1:0] lval;
		logic                          lvalid;
		logic                          lle;
		logic signed [VALUE_WIDTH-1:0] rval;
		logic                          rvalid;

		if (g == 0) begin : g_first
			assign lval   = key;
			assign lvalid = 1'b0;
			assign lle    = 1'b1;
		end else begin : g_mid_l
			assign lval   = value_w[g-1];
			assign lvalid = valid_w[g-1];
			assign lle    = le_w[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign rval   = value_w[g];
			assign rvalid = 1'b0;
		end else begin : g_mid_r
			assign rval   = value_w[g+1];
			assign rvalid = valid_w[g+1];
		end

		ste_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key        (key),
			.left_value (lval),
			.left_valid (lvalid),
			.left_le    (lle),
			.right_value(rval),
			.right_valid(rvalid),
			.value_q    (value_w[g]),
			.valid_q    (valid_w[g]),
			.le         (le_w[g]),
			.lt         (lt_w[g]),
			.eq         (eq_w[g])
		);
	end

	// Status and position come from the chain before it updates: an insert
	// lands after every entry not greater than the key, a match sits after
	// every entry less than the key.
	always_comb begin
		status_w = ste_pkg::ST_DONE;
		pos_w    = '0;
		case (cmd)
			ste_pkg::CMD_INSERT: begin
				if (full) begin
					status_w = ste_pkg::ST_FULL;
				end else begin
					pos_w = ones(le_w);
				end
			end
			ste_pkg::CMD_DELETE, ste_pkg::CMD_SEARCH: begin
				if (hit) begin
					pos_w = ones(lt_w);
				end else begin
					status_w = ste_pkg::ST_MISSING;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.en) begin
			case (cmd)
				ste_pkg::CMD_INSERT: count_q <= count_q + CW'(1);
				ste_pkg::CMD_DELETE: begin
					if (hit) begin
						count_q <= count_q - CW'(1);
					end
				end
				ste_pkg::CMD_CLEAR:  count_q <= '0;
				default: begin
				end
			endcase
		end
	end

	// Result stage: holds status and position while the chain settles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_w;
			pos_s1    <= ste_pkg::POS_WIDTH'(pos_w);
		end
	end

	// Smallest is slot 0; largest is the one valid slot whose right
	// neighbor is empty. Both read the chain after the update.
	always_comb begin
		largest_w = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (valid_w[k] && (k == DEPTH - 1 || !valid_w[(k + 1) % DEPTH])) begin
				largest_w = largest_w | value_w[k];
			end
		end
	end

	assign smallest_32 = valid_w[0] ? 32'(value_w[0]) : 32'sd0;
	assign largest_32  = 32'(largest_w);

	// Output register: the next command can enter while a result waits here.
	assign move = s1_valid_q && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (move) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			m_tuser_q <= status_s1;
			m_tdata_q <= {7'd0, largest_32, smallest_32,
				ste_pkg::CNT_WIDTH'(count_q), pos_s1};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// The chain always holds exactly as many valid bits as the count says.
	a_count_matches_cells : assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == int'(count_q))
		else $error("cell valid bits disagree with entry count");

	a_count_bounded : assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= DEPTH)
		else $error("entry count above depth");

	a_refused_keeps_count : assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == ste_pkg::CMD_INSERT && full |=> $stable(count_q))
		else $error("refused insert changed the table");

	a_accept_fills_stage : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q && !s_tready)
		else $error("accepted command did not reach the result stage");

	a_search_keeps_count : assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == ste_pkg::CMD_SEARCH |=> $stable(count_q))
		else $error("search changed the entry count");

endmodule
